### src/eic_pkg.sv
// ----------------------------------------------------------------------------
// eic_pkg
// Shared types and constants of the external interrupt controller: request
// and register codes, transaction payloads, and the lane control/result
// structs.
// ----------------------------------------------------------------------------
package eic_pkg;

  localparam int FIELD_W = 19;  // width of every per-line word on the ports
  localparam int IRQ_W   = 9;   // grouped interrupt request vector

  // Grouped request boundaries
  localparam int SINGLE_LO_CNT = 5;   // lines 0..4 map one to one
  localparam int GRP_A_LO      = 5;   // lines 5..9 share one request
  localparam int GRP_A_HI      = 9;
  localparam int GRP_B_LO      = 10;  // lines 10..15 share one request
  localparam int GRP_B_HI      = 15;
  localparam int LINE_C        = 16;
  localparam int LINE_D        = 17;

  typedef enum logic [1:0] {
    REQ_READ   = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_SAMPLE = 2'd2,
    REQ_NONE   = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ADDR_IMASK   = 3'd0,
    ADDR_EMASK   = 3'd1,
    ADDR_RISE    = 3'd2,
    ADDR_FALL    = 3'd3,
    ADDR_SWTRIG  = 3'd4,
    ADDR_PENDING = 3'd5,
    ADDR_RSVD6   = 3'd6,
    ADDR_RSVD7   = 3'd7
  } reg_addr_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         reg_addr;
    logic [FIELD_W-1:0] write_data;
    logic [FIELD_W-1:0] line_levels;
  } eic_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] read_data;
    logic [IRQ_W-1:0]   irq_vector;
    logic [FIELD_W-1:0] event_pulse;
  } eic_out_t;

  // Decoded request broadcast to every lane
  typedef struct packed {
    logic      fire;
    req_kind_t kind;
    reg_addr_t addr;
  } eic_ctrl_t;

  // What one lane reports for the current transaction
  typedef struct packed {
    logic rd_bit;
    logic irq_bit;
    logic ev_bit;
  } eic_lane_out_t;

endpackage

### src/eic_lane.sv
// ----------------------------------------------------------------------------
// eic_lane
// One interrupt line: masks, trigger selects, software trigger, pending and
// last sampled level, with edge detection and register access for its bit.
// ----------------------------------------------------------------------------
module eic_lane (
  input  logic                   clk,
  input  logic                   rst,
  input  eic_pkg::eic_ctrl_t     ctrl,
  input  logic                   wd,
  input  logic                   lv,
  output eic_pkg::eic_lane_out_t result
);

  logic imask, emask, rise, fall, sw, pend, prev;
  logic imask_next, emask_next, rise_next, fall_next, sw_next, pend_next, prev_next;
  logic edge_hit;
  logic rd_bit;

  always_comb begin
    imask_next = imask;
    emask_next = emask;
    rise_next  = rise;
    fall_next  = fall;
    sw_next    = sw;
    pend_next  = pend;
    prev_next  = prev;
    edge_hit   = 1'b0;
    rd_bit     = 1'b0;
    unique case (ctrl.kind)
      eic_pkg::REQ_READ: begin
        unique case (ctrl.addr)
          eic_pkg::ADDR_IMASK:   rd_bit = imask;
          eic_pkg::ADDR_EMASK:   rd_bit = emask;
          eic_pkg::ADDR_RISE:    rd_bit = rise;
          eic_pkg::ADDR_FALL:    rd_bit = fall;
          eic_pkg::ADDR_SWTRIG:  rd_bit = sw;
          eic_pkg::ADDR_PENDING: rd_bit = pend;
          default:               rd_bit = 1'b0;
        endcase
      end
      eic_pkg::REQ_WRITE: begin
        unique case (ctrl.addr)
          eic_pkg::ADDR_IMASK: imask_next = wd;
          eic_pkg::ADDR_EMASK: emask_next = wd;
          eic_pkg::ADDR_RISE:  rise_next  = wd;
          eic_pkg::ADDR_FALL:  fall_next  = wd;
          eic_pkg::ADDR_SWTRIG: begin
            // only a fresh 0->1 trigger raises pending, and only if unmasked
            sw_next   = sw | wd;
            pend_next = pend | (wd & ~sw & imask);
          end
          eic_pkg::ADDR_PENDING: begin
            // write-one-to-clear, takes the software trigger with it
            pend_next = pend & ~wd;
            sw_next   = sw & ~wd;
          end
          default: ;
        endcase
      end
      eic_pkg::REQ_SAMPLE: begin
        edge_hit  = (lv & ~prev & rise) | (~lv & prev & fall);
        pend_next = pend | edge_hit;
        prev_next = lv;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      imask <= 1'b0;
      emask <= 1'b0;
      rise  <= 1'b0;
      fall  <= 1'b0;
      sw    <= 1'b0;
      pend  <= 1'b0;
      prev  <= 1'b0;
    end else if (ctrl.fire) begin
      imask <= imask_next;
      emask <= emask_next;
      rise  <= rise_next;
      fall  <= fall_next;
      sw    <= sw_next;
      pend  <= pend_next;
      prev  <= prev_next;
    end
  end

  assign result.rd_bit  = rd_bit;
  assign result.irq_bit = pend_next & imask_next;
  assign result.ev_bit  = edge_hit & emask;

endmodule

### src/eic_merge.sv
// ----------------------------------------------------------------------------
// eic_merge
// Gathers the lane bits into read data, event pulses and the grouped request
// vector, and holds results in an output register backed by a skid stage.
// ----------------------------------------------------------------------------
module eic_merge #(
  parameter int LANES = 19
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_fire,
  input  eic_pkg::eic_lane_out_t lane_res [LANES],
  output logic                   skid_full,
  output logic                   out_valid,
  input  logic                   out_ready,
  output eic_pkg::eic_out_t      out_data
);

  logic [eic_pkg::FIELD_W-1:0] rd_word, ev_word, req_word;
  eic_pkg::eic_out_t           merged;
  eic_pkg::eic_out_t           skid_data;
  logic                        skid_valid;

  always_comb begin
    for (int i = 0; i < eic_pkg::FIELD_W; i++) begin
      if (i < LANES) begin
        rd_word[i]  = lane_res[i].rd_bit;
        ev_word[i]  = lane_res[i].ev_bit;
        req_word[i] = lane_res[i].irq_bit;
      end else begin
        rd_word[i]  = 1'b0;
        ev_word[i]  = 1'b0;
        req_word[i] = 1'b0;
      end
    end
  end

  always_comb begin
    merged.read_data   = rd_word;
    merged.event_pulse = ev_word;
    merged.irq_vector  = {
      req_word[eic_pkg::LINE_D],
      req_word[eic_pkg::LINE_C],
      |req_word[eic_pkg::GRP_B_HI:eic_pkg::GRP_B_LO],
      |req_word[eic_pkg::GRP_A_HI:eic_pkg::GRP_A_LO],
      req_word[eic_pkg::SINGLE_LO_CNT-1:0]
    };
  end

  // Output register plus one skid entry; the skid fills only while the
  // output register is stalled, and drains into it first.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || in_fire;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : merged;
    end else if (in_fire) begin
      skid_data <= merged;
    end
  end

  assign skid_full = skid_valid;

endmodule

### src/external_interrupt_controller_top.sv
// ----------------------------------------------------------------------------
// external_interrupt_controller_top
// Each transaction is a register read, a register write or a sample of the
// input lines, and yields exactly one result. One lane per line holds that
// line's masks, trigger selects, software trigger, pending bit and last
// level; all lanes act on a transaction in the same cycle and a merge stage
// builds read data, event pulses and the nine grouped interrupt requests
// (from pending AND interrupt mask after the update). The block takes one
// transaction per clock while its skid entry is empty; a result is held in
// an output register, and a skid entry behind it keeps input accepted for
// one more transaction while the output is stalled. Only the low NUM_LINES
// bits (at most the 19 port bits) are live; other bits are ignored and read
// as zero.
// ----------------------------------------------------------------------------
module external_interrupt_controller_top #(
  parameter int NUM_LINES = 19
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  eic_pkg::eic_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output eic_pkg::eic_out_t out_data
);

  localparam int LANES = (NUM_LINES < eic_pkg::FIELD_W) ? NUM_LINES : eic_pkg::FIELD_W;

  eic_pkg::eic_ctrl_t     ctrl;
  eic_pkg::eic_lane_out_t lane_res [LANES];
  logic                   skid_full;
  logic                   in_fire;

  assign in_ready  = !skid_full;
  assign in_fire   = in_valid && in_ready;

  assign ctrl.fire = in_fire;
  assign ctrl.kind = eic_pkg::req_kind_t'(in_data.req_type);
  assign ctrl.addr = eic_pkg::reg_addr_t'(in_data.reg_addr);

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    eic_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .wd     (in_data.write_data[i]),
      .lv     (in_data.line_levels[i]),
      .result (lane_res[i])
    );
  end

  eic_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .lane_res  (lane_res),
    .skid_full (skid_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // skid entry is only ever occupied behind a held result
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("skid occupied with empty output register");

  // a transaction taken while the output stalls lands in the skid
  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (in_fire && out_valid && !out_ready) |=> !in_ready)
    else $error("stalled transaction not held in skid");

  // after every accepted transaction the output register holds a result next cycle
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted transaction produced no result");
`endif

endmodule
